// File: src/ppp_pkg.sv
`default_nettype none
package ppp_pkg;

    localparam int CAM_W  = 34;   // camera coordinate, 22 fraction bits
    localparam int DEN_W  = 33;   // -Z, always positive when used
    localparam int PRE_W  = 51;   // f*c + 256*den
    localparam int NUM_W  = 64;   // numerator after scaling by the image size
    localparam int DIV_W  = DEN_W + 9;
    localparam int QBITS  = 15;   // quotient bits below the saturation point
    localparam int ADDR_W = 6;

    typedef enum logic [2:0] {
        REG_ROW_X        = 3'd0,
        REG_ROW_Y        = 3'd1,
        REG_ROW_Z        = 3'd2,
        REG_FOCAL_X      = 3'd3,
        REG_FOCAL_Y      = 3'd4,
        REG_IMAGE_WIDTH  = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] row_x;
        logic [63:0] row_y;
        logic [63:0] row_z;
        logic [15:0] focal_x;
        logic [15:0] focal_y;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        row_x:        64'd16384,
        row_y:        64'd1073741824,
        row_z:        64'd70368744177664,
        focal_x:      16'd256,
        focal_y:      16'd256,
        image_width:  13'd640,
        image_height: 13'd480
    };

endpackage
`default_nettype wire

// File: src/ppp_ifs.sv
`default_nettype none
interface ppp_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface ppp_pixel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_u;
    logic signed [15:0] pixel_v;
    logic               behind_camera;
    logic               outside_image;
    modport source (output valid, output pixel_u, output pixel_v, output behind_camera,
                    output outside_image, input ready);
    modport sink   (input valid, input pixel_u, input pixel_v, input behind_camera,
                    input outside_image, output ready);
endinterface
`default_nettype wire

// File: src/ppp_cfg.sv
`default_nettype none
module ppp_cfg (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ppp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]           pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    output ppp_pkg::t_cfg              o_cfg
);
    import ppp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_ROW_X:        r_cfg.row_x        <= pwdata;
                REG_ROW_Y:        r_cfg.row_y        <= pwdata;
                REG_ROW_Z:        r_cfg.row_z        <= pwdata;
                REG_FOCAL_X:      r_cfg.focal_x      <= pwdata[15:0];
                REG_FOCAL_Y:      r_cfg.focal_y      <= pwdata[15:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[12:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[12:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ROW_X:        prdata = r_cfg.row_x;
            REG_ROW_Y:        prdata = r_cfg.row_y;
            REG_ROW_Z:        prdata = r_cfg.row_z;
            REG_FOCAL_X:      prdata = {48'd0, r_cfg.focal_x};
            REG_FOCAL_Y:      prdata = {48'd0, r_cfg.focal_y};
            REG_IMAGE_WIDTH:  prdata = {51'd0, r_cfg.image_width};
            REG_IMAGE_HEIGHT: prdata = {51'd0, r_cfg.image_height};
            default:          prdata = 64'd0;
        endcase
    end
endmodule
`default_nettype wire

// File: src/ppp_xform.sv
`default_nettype none
module ppp_xform (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [15:0]           i_x,
    input  wire logic signed [15:0]           i_y,
    input  wire logic signed [15:0]           i_z,
    input  wire ppp_pkg::t_cfg                i_cfg,
    output logic                              o_valid,
    output logic signed [ppp_pkg::CAM_W-1:0]  o_cam_x,
    output logic signed [ppp_pkg::CAM_W-1:0]  o_cam_y,
    output logic [ppp_pkg::DEN_W-1:0]         o_den,
    output logic                              o_behind
);
    import ppp_pkg::*;

    logic [63:0]              w_row [3];
    logic signed [15:0]       w_pt  [3];
    logic signed [31:0]       r_prod [3][3];
    logic signed [15:0]       r_off [3];
    logic signed [CAM_W-1:0]  w_cam [3];
    logic                     r_v1;
    logic                     r_v2;
    logic signed [CAM_W-1:0]  r_cam_x;
    logic signed [CAM_W-1:0]  r_cam_y;
    logic [DEN_W-1:0]         r_den;
    logic                     r_behind;

    assign w_row[0] = i_cfg.row_x;
    assign w_row[1] = i_cfg.row_y;
    assign w_row[2] = i_cfg.row_z;
    assign w_pt[0]  = i_x;
    assign w_pt[1]  = i_y;
    assign w_pt[2]  = i_z;

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_coef
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_prod[r][j] <= 32'($signed(w_row[r][16*j +: 16])) * 32'(w_pt[j]);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_off[r] <= $signed(w_row[r][63:48]);
            end
        end
        assign w_cam[r] = CAM_W'(r_prod[r][0]) + CAM_W'(r_prod[r][1])
                        + CAM_W'(r_prod[r][2]) + CAM_W'($signed({r_off[r], 14'd0}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cam_x  <= w_cam[0];
            r_cam_y  <= w_cam[1];
            r_den    <= DEN_W'(-w_cam[2]);
            r_behind <= !w_cam[2][CAM_W-1];
        end
    end

    assign o_valid  = r_v2;
    assign o_cam_x  = r_cam_x;
    assign o_cam_y  = r_cam_y;
    assign o_den    = r_den;
    assign o_behind = r_behind;
endmodule
`default_nettype wire

// File: src/ppp_scale.sv
`default_nettype none
module ppp_scale (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [ppp_pkg::CAM_W-1:0] i_cam_x,
    input  wire logic signed [ppp_pkg::CAM_W-1:0] i_cam_y,
    input  wire logic [ppp_pkg::DEN_W-1:0]    i_den,
    input  wire logic                         i_behind,
    input  wire ppp_pkg::t_cfg                i_cfg,
    output logic                              o_valid,
    output logic signed [ppp_pkg::NUM_W-1:0]  o_num [2],
    output logic [ppp_pkg::DIV_W-1:0]         o_div,
    output logic                              o_behind
);
    import ppp_pkg::*;

    logic [15:0]              w_f    [2];
    logic [12:0]              w_size [2];
    logic signed [CAM_W-1:0]  w_cam  [2];
    logic signed [PRE_W-1:0]  r_pre  [2];
    logic signed [NUM_W-1:0]  r_num  [2];
    logic [DEN_W-1:0]         r_den;
    logic [DIV_W-1:0]         r_div;
    logic                     r_v3;
    logic                     r_v4;
    logic                     r_beh3;
    logic                     r_beh4;

    assign w_f[0]    = i_cfg.focal_x;
    assign w_f[1]    = i_cfg.focal_y;
    assign w_size[0] = i_cfg.image_width;
    assign w_size[1] = i_cfg.image_height;
    assign w_cam[0]  = i_cam_x;
    assign w_cam[1]  = i_cam_y;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pre[l] <= PRE_W'($signed({1'b0, w_f[l]})) * PRE_W'(w_cam[l])
                          + PRE_W'($signed({1'b0, i_den, 8'd0}));
                r_num[l] <= NUM_W'(r_pre[l]) * NUM_W'($signed({1'b0, w_size[l]}));
            end
        end
        assign o_num[l] = r_num[l];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= i_den;
            r_div  <= {r_den, 9'd0};
            r_beh3 <= i_behind;
            r_beh4 <= r_beh3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    assign o_valid  = r_v4;
    assign o_div    = r_div;
    assign o_behind = r_beh4;
endmodule
`default_nettype wire

// File: src/ppp_div.sv
`default_nettype none
module ppp_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [ppp_pkg::NUM_W-1:0] i_num [2],
    input  wire logic [ppp_pkg::DIV_W-1:0]    i_div,
    input  wire logic                         i_behind,
    output logic                              o_valid,
    output logic signed [15:0]                o_quo [2],
    output logic                              o_behind
);
    import ppp_pkg::*;

    // Floor division as one's complement: floor(n/d) = ~floor(~n/d) for n < 0.
    logic [NUM_W-1:0] r_rem [QBITS+1][2];
    logic [QBITS-1:0] r_quo [QBITS+1][2];
    logic             r_neg [QBITS+1][2];
    logic             r_ovf [QBITS+1][2];
    logic [DIV_W-1:0] r_div [QBITS+1];
    logic             r_beh [QBITS+1];
    logic             r_vld [QBITS+1];
    logic [NUM_W-1:0] w_mag [2];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign w_mag[l] = i_num[l] ^ {NUM_W{i_num[l][NUM_W-1]}};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][l] <= w_mag[l];
                r_quo[0][l] <= '0;
                r_neg[0][l] <= i_num[l][NUM_W-1];
                r_ovf[0][l] <= w_mag[l] >= NUM_W'({i_div, QBITS'(0)});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div[0] <= i_div;
            r_beh[0] <= i_behind;
        end
    end

    for (genvar s = 0; s < QBITS; s++) begin : g_step
        localparam int K = QBITS - 1 - s;
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [NUM_W-1:0] w_sub;
            logic             w_ge;
            assign w_sub = NUM_W'(r_div[s]) << K;
            assign w_ge  = r_rem[s][l] >= w_sub;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1][l] <= w_ge ? r_rem[s][l] - w_sub : r_rem[s][l];
                    r_quo[s+1][l] <= r_quo[s][l] | (QBITS'(w_ge) << K);
                    r_neg[s+1][l] <= r_neg[s][l];
                    r_ovf[s+1][l] <= r_ovf[s][l];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[s+1] <= r_div[s];
                r_beh[s+1] <= r_beh[s];
            end
        end
    end

    for (genvar s = 0; s <= QBITS; s++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= (s == 0) ? i_valid : r_vld[(s == 0) ? 0 : s-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_out
        logic [15:0] w_q;
        assign w_q = r_ovf[QBITS][l] ? 16'h7fff : {1'b0, r_quo[QBITS][l]};
        assign o_quo[l] = $signed(r_neg[QBITS][l] ? ~w_q : w_q);
    end

    assign o_valid  = r_vld[QBITS];
    assign o_behind = r_beh[QBITS];
endmodule
`default_nettype wire

// File: src/point_perspective_projection_top.sv
`default_nettype none
// channel   dir  payload                                           handshake
// i_point   in   point_x, point_y, point_z (s16 Q8.8)              valid/ready
// o_pixel   out  pixel_u, pixel_v (s16), behind_camera, outside_image valid/ready
// apb       in   row_x/y/z (64), focal_x/y, image_width/height     psel/penable
//
// One point per cycle unless o_pixel stalls; 2 transform, 2 scaling, 16 divider,
// 1 output register stages. Each divider step retires one quotient bit per lane.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stall on o_pixel freezes every stage at once; i_point.ready drops only
// while the output register holds a beat that is not taken.
module point_perspective_projection_top (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    ppp_point_if.sink                   i_point,
    ppp_pixel_if.source                 o_pixel,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ppp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]            pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    import ppp_pkg::*;

    t_cfg                    w_cfg;
    logic                    w_en;
    logic                    w_xf_valid;
    logic signed [CAM_W-1:0] w_cam_x;
    logic signed [CAM_W-1:0] w_cam_y;
    logic [DEN_W-1:0]        w_den;
    logic                    w_xf_behind;
    logic                    w_sc_valid;
    logic signed [NUM_W-1:0] w_num [2];
    logic [DIV_W-1:0]        w_div;
    logic                    w_sc_behind;
    logic                    w_dv_valid;
    logic signed [15:0]      w_quo [2];
    logic                    w_dv_behind;
    logic                    w_outside;
    logic                    r_valid;
    logic signed [15:0]      r_u;
    logic signed [15:0]      r_v;
    logic                    r_behind;
    logic                    r_outside;

    assign w_en          = !r_valid || o_pixel.ready;
    assign i_point.ready = w_en;

    ppp_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    ppp_xform u_xform (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_point.valid),
        .i_x(i_point.point_x), .i_y(i_point.point_y), .i_z(i_point.point_z),
        .i_cfg(w_cfg), .o_valid(w_xf_valid), .o_cam_x(w_cam_x), .o_cam_y(w_cam_y),
        .o_den(w_den), .o_behind(w_xf_behind)
    );

    ppp_scale u_scale (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_xf_valid),
        .i_cam_x(w_cam_x), .i_cam_y(w_cam_y), .i_den(w_den), .i_behind(w_xf_behind),
        .i_cfg(w_cfg), .o_valid(w_sc_valid), .o_num(w_num), .o_div(w_div),
        .o_behind(w_sc_behind)
    );

    ppp_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_sc_valid), .i_num(w_num),
        .i_div(w_div), .i_behind(w_sc_behind), .o_valid(w_dv_valid), .o_quo(w_quo),
        .o_behind(w_dv_behind)
    );

    assign w_outside = w_quo[0][15] || w_quo[1][15]
                    || (w_quo[0] >= $signed({3'd0, w_cfg.image_width}))
                    || (w_quo[1] >= $signed({3'd0, w_cfg.image_height}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_dv_valid;
        end
    end

    // Points behind the camera report zero coordinates and inside.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u       <= w_dv_behind ? 16'sd0 : w_quo[0];
            r_v       <= w_dv_behind ? 16'sd0 : w_quo[1];
            r_behind  <= w_dv_behind;
            r_outside <= !w_dv_behind && w_outside;
        end
    end

    assign o_pixel.valid         = r_valid;
    assign o_pixel.pixel_u       = r_u;
    assign o_pixel.pixel_v       = r_v;
    assign o_pixel.behind_camera = r_behind;
    assign o_pixel.outside_image = r_outside;
endmodule
`default_nettype wire
